/* src/rbu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_pkg: shared types and constants of the busiest-utilization unit
// Holds the field widths, status codes, divider constants and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbu_pkg;

  // Field widths of one sample beat and one result beat.
  localparam int CIDX_W = 3;
  localparam int RES_W  = 64;
  localparam int WIN_W  = 32;
  localparam int BUSY_W = 14;
  localparam int STAT_W = 2;

  // Full scale of the utilization, in hundredths of a percent.
  localparam logic [BUSY_W-1:0] FULL_SCALE = BUSY_W'(10000);

  // Product of a window-sized delta and the full scale.
  localparam int PROD_W = WIN_W + BUSY_W;

  // The quotient stays below the full scale, so it has BUSY_W bits and the
  // divider retires one of them per step.
  localparam int DIV_STEPS = BUSY_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Round status codes.
  localparam logic [STAT_W-1:0] STATUS_VALID     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_SAMPLE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ERROR     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture an accepted sample beat, start the RAM read
    logic sub;         // form delta and the backward-step flag
    logic wr_ram;      // store the current reading
    logic clr_valid;   // invalidate the counter
    logic set_valid;   // mark the counter's reading valid
    logic mark_sample; // a successful read moves error to no-sample
    logic set_full;    // delta reached the window: quotient is full scale
    logic mul;         // load the divider with delta times full scale
    logic div_step;    // one restoring division step
    logic upd;         // fold the busy value into the round maximum
    logic emit;        // present the round result and restart the round
  } rbu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;        // counter index out of range
    logic fail;        // read failed
    logic refresh;     // zero window, no valid reading or backward step
    logic ge_window;   // delta reaches the window
    logic last;        // sample closes the round
    logic out_busy;    // result register is full and stalled
  } rbu_stat_t;

endpackage

/* src/rbu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/rbu_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_ctrl: sequencing controller of the busiest-utilization unit
// Walks one sample beat through read, subtract, decide, multiply, divide,
// update and round-end steps, and counts the divider steps.
// ----------------------------------------------------------------------------
module rbu_ctrl import rbu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rbu_stat_t stat,
  output rbu_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_DEC,
    S_MUL,
    S_DIV,
    S_UPD,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Sample beats are taken only between samples.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        priority if (stat.skip) begin
          state_nxt = S_FIN;
        end else if (stat.fail) begin
          cmd.clr_valid = 1'b1;
          state_nxt     = S_FIN;
        end else if (stat.refresh) begin
          cmd.wr_ram      = 1'b1;
          cmd.set_valid   = 1'b1;
          cmd.mark_sample = 1'b1;
          state_nxt       = S_FIN;
        end else if (stat.ge_window) begin
          cmd.wr_ram      = 1'b1;
          cmd.set_valid   = 1'b1;
          cmd.mark_sample = 1'b1;
          cmd.set_full    = 1'b1;
          state_nxt       = S_UPD;
        end else begin
          cmd.wr_ram      = 1'b1;
          cmd.set_valid   = 1'b1;
          cmd.mark_sample = 1'b1;
          state_nxt       = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The divider never runs past its last quotient bit.
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divider step count out of range");

  // Every multiply is followed by a full run of division steps.
  a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> (state_r == S_DIV) && (cnt_r == '0))
    else $error("divider did not start after multiply");

endmodule

/* src/rbu_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_dpath: datapath of the busiest-utilization unit
// Holds the sample beat, the previous-reading RAM and valid bits, the delta
// and restoring divider, the round maximum and the result register.
// ----------------------------------------------------------------------------
module rbu_dpath import rbu_pkg::*; #(
  parameter int NUM_COUNTERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CIDX_W-1:0] in_counter_index,
  input  logic              in_read_ok,
  input  logic [RES_W-1:0]  in_residency_ms,
  input  logic [WIN_W-1:0]  in_window_ms,
  input  logic              in_round_end,
  input  rbu_cmd_t          cmd,
  output rbu_stat_t         stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BUSY_W-1:0] out_busy_level,
  output logic [STAT_W-1:0] out_round_status
);

  localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int EXT_W = (IDX_W > CIDX_W) ? IDX_W : CIDX_W;

  // Captured sample beat.
  logic [CIDX_W-1:0] idx_r;
  logic              ok_r;
  logic [RES_W-1:0]  cur_r;
  logic [WIN_W-1:0]  win_r;
  logic              last_r;

  // Counter addressing.
  logic [EXT_W-1:0]  in_idx_ext, idx_ext;
  logic [IDX_W-1:0]  in_addr, addr;
  logic [RES_W-1:0]  prev;

  // Per-counter valid bits.
  logic [NUM_COUNTERS-1:0] valid_r;

  // Delta and divider.
  logic [RES_W-1:0]  delta_r;
  logic              back_r;
  logic [WIN_W-1:0]  rem_r;
  logic [BUSY_W-1:0] low_r;
  logic [PROD_W-1:0] prod;
  logic [WIN_W+1:0]  trial;
  logic              qbit;

  // Round accumulation and result register.
  logic [BUSY_W-1:0] best_r;
  logic [STAT_W-1:0] acc_r;
  logic [BUSY_W-1:0] util;
  logic              out_valid_r;
  logic [BUSY_W-1:0] out_busy_r;
  logic [STAT_W-1:0] out_status_r;

  assign in_idx_ext = EXT_W'(in_counter_index);
  assign idx_ext    = EXT_W'(idx_r);
  assign in_addr    = in_idx_ext[IDX_W-1:0];
  assign addr       = idx_ext[IDX_W-1:0];

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r  <= in_counter_index;
      ok_r   <= in_read_ok;
      cur_r  <= in_residency_ms;
      win_r  <= in_window_ms;
      last_r <= in_round_end;
    end
  end

  // Previous readings, read as the beat is accepted.
  rbu_ram #(
    .WIDTH (RES_W),
    .DEPTH (NUM_COUNTERS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (cmd.wr_ram),
    .waddr (addr),
    .wdata (cur_r),
    .re    (cmd.load),
    .raddr (in_addr),
    .rdata (prev)
  );

  // Valid bit per counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr_valid) begin
      valid_r[addr] <= 1'b0;
    end else if (cmd.set_valid) begin
      valid_r[addr] <= 1'b1;
    end
  end

  // Delta against the previous reading and the backward-step flag.
  always_ff @(posedge clk) begin
    if (cmd.sub) begin
      delta_r <= cur_r - prev;
      back_r  <= (cur_r < prev);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.skip      = (32'(idx_r) >= NUM_COUNTERS);
    stat.fail      = !ok_r;
    stat.refresh   = (win_r == '0) || !valid_r[addr] || back_r;
    stat.ge_window = (|delta_r[RES_W-1:WIN_W]) || (delta_r[WIN_W-1:0] >= win_r);
    stat.last      = last_r;
    stat.out_busy  = out_valid_r && out_stall;
  end

  // Restoring division of delta * full scale by the window. The upper part of
  // the product is already below the window, so it seeds the remainder and the
  // low BUSY_W bits are shifted in one per step while the quotient shifts into low_r.
  assign prod  = PROD_W'(delta_r[WIN_W-1:0]) * PROD_W'(FULL_SCALE);
  assign trial = {1'b0, rem_r, low_r[BUSY_W-1]} - {2'b00, win_r};
  assign qbit  = !trial[WIN_W+1];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:BUSY_W];
      low_r <= prod[BUSY_W-1:0];
    end else if (cmd.set_full) begin
      low_r <= FULL_SCALE;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? trial[WIN_W-1:0] : {rem_r[WIN_W-2:0], low_r[BUSY_W-1]};
      low_r <= {low_r[BUSY_W-2:0], qbit};
    end
  end

  assign util = FULL_SCALE - low_r;

  // Round maximum and status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      acc_r  <= STATUS_ERROR;
    end else if (cmd.emit) begin
      best_r <= '0;
      acc_r  <= STATUS_ERROR;
    end else if (cmd.upd) begin
      if ((acc_r != STATUS_VALID) || (util > best_r)) begin
        best_r <= util;
        acc_r  <= STATUS_VALID;
      end
    end else if (cmd.mark_sample) begin
      if (acc_r == STATUS_ERROR) begin
        acc_r <= STATUS_NO_SAMPLE;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_busy_r   <= (acc_r == STATUS_VALID) ? best_r : '0;
      out_status_r <= acc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_busy_level   = out_busy_r;
  assign out_round_status = out_status_r;

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("round result overwritten while stalled");

  // Only a valid round carries a nonzero busy level, and never above full scale.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_round_status == STATUS_VALID) || (out_busy_r == '0))
                    && (out_busy_r <= FULL_SCALE))
    else $error("round result out of range");

  // The partial remainder stays below the divisor while dividing.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < win_r))
    else $error("divider remainder not below window");

  // The status accumulator holds one of its three codes.
  a_acc_code: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r == STATUS_VALID) || (acc_r == STATUS_NO_SAMPLE) || (acc_r == STATUS_ERROR))
    else $error("round status accumulator corrupt");

endmodule

/* src/residency_busiest_utilization_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// residency_busiest_utilization_unit: busiest counter from idle residency
// Derives each counter's busy level from successive idle-residency readings and
// reports the maximum of a round together with a status on the round's last
// sample beat.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time. A beat that yields no busy value (index
// out of range, failed read, zero window, first reading or backward step)
// passes through read, subtract, decide and finish; one whose idle delta
// reaches the window adds an update; any other also adds a multiply and the
// 14-step restoring divider forming idle * 10000 / window one quotient bit per
// cycle. A round-end beat also waits while a previous round result is still
// stalled on the output. The previous readings live in a small RAM with one
// entry per counter; readings are only used after the counter's valid bit is
// set, and reset clears the valid bits at once, so no clearing pass is needed.
module residency_busiest_utilization_unit import rbu_pkg::*; #(
  parameter int NUM_COUNTERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CIDX_W-1:0] in_counter_index,
  input  logic              in_read_ok,
  input  logic [RES_W-1:0]  in_residency_ms,
  input  logic [WIN_W-1:0]  in_window_ms,
  input  logic              in_round_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BUSY_W-1:0] out_busy_level,
  output logic [STAT_W-1:0] out_round_status
);

  rbu_cmd_t  cmd;
  rbu_stat_t stat;

  // Sequencing.
  rbu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  rbu_dpath #(
    .NUM_COUNTERS (NUM_COUNTERS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_counter_index (in_counter_index),
    .in_read_ok       (in_read_ok),
    .in_residency_ms  (in_residency_ms),
    .in_window_ms     (in_window_ms),
    .in_round_end     (in_round_end),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_busy_level   (out_busy_level),
    .out_round_status (out_round_status)
  );

endmodule
